// ===== hw/rtl/dsac_pkg.sv =====
// Shared types and constants of the dust sensor average and convert block.
`default_nettype none

package dsac_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int MV_W      = 16;
   localparam int DENSITY_W = 24;
   localparam int SCALE_W   = 16;
   localparam int GAIN_W    = 5;
   localparam int OFFSET_W  = 16;
   localparam int DPMV_W    = 8;
   localparam int MV_FRAC_W = 10;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MV_PER_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVIDER_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_DUST_MV    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY_PER_MV = 2'd3;

   localparam logic [SCALE_W-1:0]  RESET_MV_PER_COUNT   = 16'd5000;
   localparam logic [GAIN_W-1:0]   RESET_DIVIDER_GAIN   = 5'd11;
   localparam logic [OFFSET_W-1:0] RESET_NO_DUST_MV     = 16'd600;
   localparam logic [DPMV_W-1:0]   RESET_DENSITY_PER_MV = 8'd51;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [SCALE_W-1:0]  mv_per_count_q10;
      logic [GAIN_W-1:0]   divider_gain;
      logic [OFFSET_W-1:0] no_dust_mv;
      logic [DPMV_W-1:0]   density_per_mv_q8;
   } cfg_type;

   // prime: first sample after reset, fills the whole window
   typedef struct packed {
      logic                prime;
      logic [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_MV1,
      BK_MV2,
      BK_DENS
   } back_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dsac_req_if.sv =====
// Sample channel: valid, ready and one raw ADC count per beat.
`default_nettype none

interface dsac_req_if import dsac_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dsac_rsp_if.sv =====
// Result channel: valid, ready and the average, voltage and density of one beat.
`default_nettype none

interface dsac_rsp_if import dsac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SAMPLE_W-1:0]  average_count;
   logic [MV_W-1:0]      sensed_mv;
   logic [DENSITY_W-1:0] density_q8;

   modport source (output valid, output average_count, output sensed_mv,
                   output density_q8, input ready);
   modport sink   (input valid, input average_count, input sensed_mv,
                   input density_q8, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dsac_front.sv =====
// Front end: accepts sample beats and tags the first one after reset as priming.
`default_nettype none

module dsac_front import dsac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   dsac_req_if.sink      req_ch,
   input  logic          queue_full,
   output push_type      push
);

   logic primed_ff;
   logic primed_in;
   logic accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign primed_in    = primed_ff || accept;

   always_comb begin
      push.push        = accept;
      push.item.prime  = !primed_ff;
      push.item.sample = req_ch.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else begin
         primed_ff <= primed_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dsac_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none

module dsac_queue import dsac_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dsac_back.sv =====
// Back end: window memory, running sum, average and the conversion multiplies.
`default_nettype none

module dsac_back import dsac_pkg::*; #(
   parameter int WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  head_type    head,
   output logic        pop,
   dsac_rsp_if.source  rsp_ch
);

   localparam int WIN_LOG = $clog2(WINDOW);
   localparam int SLOT_W  = (WINDOW > 1) ? WIN_LOG : 1;
   localparam int SUM_W   = SAMPLE_W + WIN_LOG;
   localparam int SHIFT   = SUM_W + WIN_LOG;
   localparam int RECIP_W = SUM_W + 1;
   localparam int QPROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + WINDOW - 1) / WINDOW);
   localparam int MVP_W   = SAMPLE_W + SCALE_W;
   localparam int FULL_W  = MVP_W + GAIN_W;

   back_state_type state_ff;
   back_state_type state_in;

   logic [SAMPLE_W-1:0] window_mem [WINDOW];
   logic [SAMPLE_W-1:0] old_ff;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] sample_in;
   logic                prime_ff;
   logic                prime_in;
   logic [SAMPLE_W-1:0] fill_value_ff;
   logic [SAMPLE_W-1:0] fill_value_in;
   logic                lapped_ff;
   logic                lapped_in;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   slot_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [QPROD_W-1:0]  qprod_ff;
   logic [QPROD_W-1:0]  qprod_in;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [SAMPLE_W-1:0] avg_in;
   logic [MVP_W-1:0]    mvprod_ff;
   logic [MVP_W-1:0]    mvprod_in;
   logic [MV_W-1:0]     mv_ff;
   logic [MV_W-1:0]     mv_in;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [SAMPLE_W-1:0]  out_avg_ff;
   logic [MV_W-1:0]      out_mv_ff;
   logic [DENSITY_W-1:0] out_dens_ff;
   logic [DENSITY_W-1:0] dens_in;

   logic                 out_free;
   logic                 load_out;
   logic                 sum_step;
   logic                 mem_write;
   logic [SAMPLE_W-1:0]  old_value;
   logic [FULL_W-1:0]    full_mv;
   logic [FULL_W-MV_FRAC_W-1:0] mv_shifted;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: state_in = head.valid ? BK_SUM : BK_IDLE;
         BK_SUM:  state_in = BK_DIV;
         BK_DIV:  state_in = BK_MV1;
         BK_MV1:  state_in = BK_MV2;
         BK_MV2:  state_in = BK_DENS;
         BK_DENS: begin
            if (out_free) begin
               state_in = head.valid ? BK_SUM : BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      sum_step = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = head.valid;
         BK_SUM:  sum_step = 1'b1;
         BK_DENS: begin
            load_out = out_free;
            pop      = out_free && head.valid;
         end
         default: begin
         end
      endcase
   end

   assign mem_write = sum_step && !prime_ff;
   assign old_value = lapped_ff ? old_ff : fill_value_ff;

   always_comb begin
      sample_in     = pop ? head.item.sample : sample_ff;
      prime_in      = pop ? head.item.prime : prime_ff;
      fill_value_in = fill_value_ff;
      lapped_in     = lapped_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      if (sum_step) begin
         if (prime_ff) begin
            fill_value_in = sample_ff;
            lapped_in     = 1'b0;
            slot_in       = '0;
            sum_in        = SUM_W'(sample_ff) * SUM_W'(WINDOW);
         end else begin
            sum_in = sum_ff - SUM_W'(old_value) + SUM_W'(sample_ff);
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               slot_in   = '0;
               lapped_in = 1'b1;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   // average by reciprocal multiply, then the two scale multiplies
   assign qprod_in   = QPROD_W'(sum_ff) * QPROD_W'(RECIP);
   assign avg_in     = qprod_ff[SHIFT +: SAMPLE_W];
   assign mvprod_in  = MVP_W'(avg_in) * MVP_W'(cfg.mv_per_count_q10);
   assign full_mv    = FULL_W'(mvprod_ff) * FULL_W'(cfg.divider_gain);
   assign mv_shifted = full_mv[FULL_W-1:MV_FRAC_W];
   assign mv_in      = (|mv_shifted[FULL_W-MV_FRAC_W-1:MV_W]) ? {MV_W{1'b1}}
                                                               : mv_shifted[MV_W-1:0];
   assign dens_in    = (mv_ff >= cfg.no_dust_mv)
                       ? DENSITY_W'(mv_ff - cfg.no_dust_mv) * DENSITY_W'(cfg.density_per_mv_q8)
                       : '0;

   assign out_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         old_ff <= window_mem[slot_ff];
      end
      if (mem_write) begin
         window_mem[slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      prime_ff      <= prime_in;
      fill_value_ff <= fill_value_in;
      if (state_ff == BK_DIV) begin
         qprod_ff <= qprod_in;
      end
      if (state_ff == BK_MV1) begin
         avg_ff    <= avg_in;
         mvprod_ff <= mvprod_in;
      end
      if (state_ff == BK_MV2) begin
         mv_ff <= mv_in;
      end
      if (load_out) begin
         out_avg_ff  <= avg_ff;
         out_mv_ff   <= mv_ff;
         out_dens_ff <= dens_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         lapped_ff    <= 1'b0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lapped_ff    <= lapped_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.average_count = out_avg_ff;
   assign rsp_ch.sensed_mv     = out_mv_ff;
   assign rsp_ch.density_q8    = out_dens_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dust_sensor_average_convert.sv =====
// Top level of the dust sensor window average and millivolt/density converter.
`default_nettype none

// Each sample beat yields one result beat: the truncated average of the last
// WINDOW samples (the first sample after reset fills the whole window), that
// average converted to millivolts with the Q10 scale and divider gain and
// saturated at 65535, and the Q8 dust density above the no-dust offset,
// clamped at zero. Samples go into a two-entry queue; the back end handles
// one at a time, stepping through the running-sum update and the chain of
// four multiplies (reciprocal for the average, scale, gain and density),
// each followed by a register. A finished result waits in an output
// register while the next sample is worked on. Registers are written
// through csr_we, csr_index and csr_wdata; the user must do so only while no
// sample is in flight, which the block itself does not enforce.
module dust_sensor_average_convert import dsac_pkg::*; #(
   parameter int WINDOW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   dsac_req_if.sink               req_ch,
   dsac_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MV_PER_COUNT:   cfg_in.mv_per_count_q10  = csr_wdata;
            CSR_DIVIDER_GAIN:   cfg_in.divider_gain      = csr_wdata[GAIN_W-1:0];
            CSR_NO_DUST_MV:     cfg_in.no_dust_mv        = csr_wdata;
            CSR_DENSITY_PER_MV: cfg_in.density_per_mv_q8 = csr_wdata[DPMV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mv_per_count_q10  <= RESET_MV_PER_COUNT;
         cfg_ff.divider_gain      <= RESET_DIVIDER_GAIN;
         cfg_ff.no_dust_mv        <= RESET_NO_DUST_MV;
         cfg_ff.density_per_mv_q8 <= RESET_DENSITY_PER_MV;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   dsac_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   dsac_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/dust_sensor_average_convert_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the dust sensor window average and millivolt/density converter.
module dust_sensor_average_convert_tb;
   import dsac_pkg::*;

   localparam int WINDOW        = 8;
   localparam int SUM_W         = 15;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS   = 143;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  average_count;
      logic [MV_W-1:0]      sensed_mv;
      logic [DENSITY_W-1:0] density_q8;
   } reading_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dsac_req_if req_ch ();
   dsac_rsp_if rsp_ch ();

   dust_sensor_average_convert #(.WINDOW(WINDOW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfg_type             csr_shadow;
   logic [SAMPLE_W-1:0] win_samples [WINDOW];
   logic [SUM_W-1:0]    win_total;
   int unsigned         win_next;
   bit                  win_filled;
   reading_type         expected_readings [$];
   reading_type         want_reading;
   int                  error_count = 0;
   bit                  req_idle_on;
   bit                  rsp_idle_on;
   int                  rsp_hold = 0;
   logic [SAMPLE_W-1:0] sample_level;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 8);
   endfunction

   // window update and conversion for one accepted sample
   function automatic reading_type convert_reading(input logic [SAMPLE_W-1:0] sample);
      reading_type          r;
      logic [32:0]          full;
      logic [MV_W-1:0]      above;
      if (!win_filled) begin
         foreach (win_samples[i])
            win_samples[i] = sample;
         win_total  = SUM_W'(SUM_W'(sample) * WINDOW);
         win_next   = 0;
         win_filled = 1'b1;
      end else begin
         win_total = win_total - SUM_W'(win_samples[win_next]) + SUM_W'(sample);
         win_samples[win_next] = sample;
         win_next = (win_next + 1) % WINDOW;
      end
      r.average_count = SAMPLE_W'(win_total / WINDOW);
      full = (33'(r.average_count) * 33'(csr_shadow.mv_per_count_q10)
              * 33'(csr_shadow.divider_gain)) >> MV_FRAC_W;
      r.sensed_mv = (full > 33'hFFFF) ? '1 : full[MV_W-1:0];
      if (r.sensed_mv >= csr_shadow.no_dust_mv) begin
         above        = r.sensed_mv - csr_shadow.no_dust_mv;
         r.density_q8 = DENSITY_W'(above) * DENSITY_W'(csr_shadow.density_per_mv_q8);
      end else begin
         r.density_q8 = '0;
      end
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      case (index)
         CSR_MV_PER_COUNT:   csr_shadow.mv_per_count_q10  = data[SCALE_W-1:0];
         CSR_DIVIDER_GAIN:   csr_shadow.divider_gain      = data[GAIN_W-1:0];
         CSR_NO_DUST_MV:     csr_shadow.no_dust_mv        = data[OFFSET_W-1:0];
         CSR_DENSITY_PER_MV: csr_shadow.density_per_mv_q8 = data[DPMV_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] scale,
                                 input logic [CSR_DATA_W-1:0] gain,
                                 input logic [CSR_DATA_W-1:0] offset,
                                 input logic [CSR_DATA_W-1:0] dpmv);
      write_csr(CSR_MV_PER_COUNT, scale);
      write_csr(CSR_DIVIDER_GAIN, gain);
      write_csr(CSR_NO_DUST_MV, offset);
      write_csr(CSR_DENSITY_PER_MV, dpmv);
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid  = 1'b1;
      req_ch.sample = sample;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_readings.push_back(convert_reading(sample));
   endtask

   task automatic send_repeated(input logic [SAMPLE_W-1:0] sample, input int count);
      repeat (count) send_sample(sample);
   endtask

   // block is idle once every result is back and the pipeline has emptied
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (rsp_idle_on)
            rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result beat: average_count %0d sensed_mv %0d density_q8 %0d",
                   rsp_ch.average_count, rsp_ch.sensed_mv, rsp_ch.density_q8);
            error_count++;
         end else begin
            want_reading = expected_readings.pop_front();
            if (rsp_ch.average_count !== want_reading.average_count) begin
               $error("average_count: expected %0d, got %0d",
                      want_reading.average_count, rsp_ch.average_count);
               error_count++;
            end
            if (rsp_ch.sensed_mv !== want_reading.sensed_mv) begin
               $error("sensed_mv: expected %0d, got %0d",
                      want_reading.sensed_mv, rsp_ch.sensed_mv);
               error_count++;
            end
            if (rsp_ch.density_q8 !== want_reading.density_q8) begin
               $error("density_q8: expected %0d, got %0d",
                      want_reading.density_q8, rsp_ch.density_q8);
               error_count++;
            end
         end
      end
   end

   // first sample fills the window, then a run of full-scale counts
   task automatic test_priming_and_full_scale();
      send_sample(12'hA53);
      send_repeated(12'hFFF, WINDOW);
      wait_idle();
   endtask

   task automatic test_saturation();
      apply_settings(16'hFFFF, 16'd31, 16'd0, 16'd255);
      send_repeated(12'hFFF, 2);
      wait_idle();
   endtask

   task automatic test_offset_clamp();
      apply_settings(16'd5000, 16'd11, 16'hFFFF, 16'd255);
      send_sample(12'hFFF);
      send_sample(12'h555);
      wait_idle();
   endtask

   task automatic test_zero_scale_and_gain();
      apply_settings(16'd0, 16'd11, 16'd0, 16'd255);
      send_repeated(12'hFFF, 2);
      wait_idle();
      apply_settings(16'd5000, 16'd0, 16'd0, 16'd255);
      send_repeated(12'hFFF, 2);
      wait_idle();
   endtask

   task automatic test_zero_input();
      apply_settings(CSR_DATA_W'(RESET_MV_PER_COUNT), CSR_DATA_W'(RESET_DIVIDER_GAIN),
                     CSR_DATA_W'(RESET_NO_DUST_MV), CSR_DATA_W'(RESET_DENSITY_PER_MV));
      send_repeated(12'h000, WINDOW);
      send_sample(12'hAAA);
      wait_idle();
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_reg_value(input int width);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_DATA_W-1:0] field_mask;
      field_mask = CSR_DATA_W'((32'd1 << width) - 1);
      value      = CSR_DATA_W'($urandom);
      case ($urandom_range(5))
         0: value = value & ~field_mask;
         1: value = value | field_mask;
         default: ;
      endcase
      return value;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4: return SAMPLE_W'($urandom);
         default: begin
            v = int'(sample_level) + int'($urandom_range(63)) - 32;
            if (v < 0)
               v = 0;
            if (v > 4095)
               v = 4095;
            return SAMPLE_W'(v);
         end
      endcase
   endfunction

   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 2 == 0) begin
            apply_settings(CSR_DATA_W'($urandom_range(8000, 1000)),
                           CSR_DATA_W'($urandom_range(15, 1)),
                           CSR_DATA_W'($urandom_range(3000)),
                           CSR_DATA_W'($urandom_range(255)));
         end else begin
            apply_settings(pick_reg_value(SCALE_W), pick_reg_value(GAIN_W),
                           pick_reg_value(OFFSET_W), pick_reg_value(DPMV_W));
         end
         req_idle_on  = (phase % 3 != 0);
         rsp_idle_on  = (phase % 4 != 0);
         sample_level = SAMPLE_W'($urandom);
         repeat (PHASE_BEATS) send_sample(pick_sample());
         wait_idle();
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_MV_PER_COUNT;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      sample_level  = '0;
      csr_shadow.mv_per_count_q10  = RESET_MV_PER_COUNT;
      csr_shadow.divider_gain      = RESET_DIVIDER_GAIN;
      csr_shadow.no_dust_mv        = RESET_NO_DUST_MV;
      csr_shadow.density_per_mv_q8 = RESET_DENSITY_PER_MV;
      win_total  = '0;
      win_next   = 0;
      win_filled = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_priming_and_full_scale();
      test_saturation();
      test_offset_clamp();
      test_zero_scale_and_gain();
      test_zero_input();
      test_random_settings();

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== dust_sensor_average_convert.f =====
hw/rtl/dsac_pkg.sv
hw/rtl/dsac_req_if.sv
hw/rtl/dsac_rsp_if.sv
hw/rtl/dsac_front.sv
hw/rtl/dsac_queue.sv
hw/rtl/dsac_back.sv
hw/rtl/dust_sensor_average_convert.sv
tb/dust_sensor_average_convert_tb.sv
